FILE: design/wpcp_pkg.sv
// shared types, codes and magic-byte tables for the wav pcm chunk parser
`default_nettype none

package wpcp_pkg;

   // parse phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_HEAD   = 3'd1;
   localparam logic [2:0] PH_BODY   = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_FMT_SHORT = 3'd3;
   localparam logic [2:0] ST_BAD_FMT   = 3'd4;
   localparam logic [2:0] ST_NO_FMT    = 3'd5;
   localparam logic [2:0] ST_BAD_COUNT = 3'd6;
   localparam logic [2:0] ST_NO_DATA   = 3'd7;

   // csr register indexes
   localparam logic [1:0] CSR_FILE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd1;
   localparam logic [1:0] CSR_MAX_FRAMES  = 2'd2;

   // csr reset values
   localparam logic [31:0] FILE_LENGTH_RST = 32'd12;
   localparam logic [31:0] SAMPLE_RATE_RST = 32'd48000;
   localparam logic [30:0] MAX_FRAMES_RST  = 31'd96000;

   // chunk kinds
   localparam logic KIND_OTHER = 1'b0;
   localparam logic KIND_FMT   = 1'b1;

   // bytes in the riff header and fmt minimum body
   localparam logic [31:0] HEADER_BYTES = 32'd12;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

   // one result transaction
   typedef struct packed {
      logic               valid;
      logic signed [15:0] sample;
      logic [2:0]         status;
      logic               last;
   } wpcp_result_type;

   function automatic logic [7:0] riff_char(input logic [1:0] idx);
      case (idx)
         2'd0:    riff_char = 8'h52;
         2'd1:    riff_char = 8'h49;
         2'd2:    riff_char = 8'h46;
         default: riff_char = 8'h46;
      endcase
   endfunction

   function automatic logic [7:0] wave_char(input logic [1:0] idx);
      case (idx)
         2'd0:    wave_char = 8'h57;
         2'd1:    wave_char = 8'h41;
         2'd2:    wave_char = 8'h56;
         default: wave_char = 8'h45;
      endcase
   endfunction

   function automatic logic [7:0] fmt_char(input logic [1:0] idx);
      case (idx)
         2'd0:    fmt_char = 8'h66;
         2'd1:    fmt_char = 8'h6d;
         2'd2:    fmt_char = 8'h74;
         default: fmt_char = 8'h20;
      endcase
   endfunction

   function automatic logic [7:0] data_char(input logic [1:0] idx);
      case (idx)
         2'd0:    data_char = 8'h64;
         2'd1:    data_char = 8'h61;
         2'd2:    data_char = 8'h74;
         default: data_char = 8'h61;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: design/wpcp_in_stage.sv
// input register holding one accepted file byte
`default_nettype none

module wpcp_in_stage
   import wpcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_file_byte,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // free when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_file_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

`default_nettype wire

FILE: design/wpcp_parse_core.sv
// parse state and the per-byte next-state and result logic
`default_nettype none

module wpcp_parse_core
   import wpcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic        advance,
   input  wire logic [7:0]  file_byte,
   input  wire logic [31:0] file_length,
   input  wire logic [31:0] sample_rate,
   input  wire logic [30:0] max_frames,
   output wpcp_result_type  result
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] pos_ff, pos_in;
   logic        kind_ff, kind_in;
   logic [1:0]  idm_ff, idm_in;
   logic        fseen_ff, fseen_in;
   logic        fok_ff, fok_in;
   logic        magic_ff, magic_in;
   logic [7:0]  low_ff, low_in;
   logic [30:0] left_ff, left_in;

   // shared arithmetic on the current byte
   logic [32:0] offset_inc;
   logic        file_end;
   logic [31:0] size_new;
   logic        head_trunc;
   logic        head_no_room;
   logic        body_last;
   logic        body_no_room;
   logic        hdr_no_room;
   logic        fl_short;
   logic [30:0] sample_total;
   logic [30:0] left_dec;
   logic [7:0]  rate_byte;
   logic [7:0]  fmt_want;
   logic        fmt_check;
   logic        magic_cur;

   assign offset_inc   = {1'b0, offset_ff} + 33'd1;
   assign file_end     = offset_inc >= {1'b0, file_length};
   assign fl_short     = file_length < HEADER_BYTES;
   assign hdr_no_room  = file_length < (HEADER_BYTES + 32'd8);
   assign head_trunc   = ({1'b0, offset_inc} + {2'b0, size_new}) > {2'b0, file_length};
   assign head_no_room = ({1'b0, offset_inc} + 34'd8) > {2'b0, file_length};
   assign body_last    = ({1'b0, pos_ff} + 33'd1) >= {1'b0, size_ff};
   assign body_no_room = ({1'b0, offset_inc} + {33'b0, size_ff[0]} + 34'd8)
                         > {2'b0, file_length};
   assign sample_total = size_new[31:1];
   assign left_dec     = (left_ff != 31'd0) ? (left_ff - 31'd1) : left_ff;

   // little-endian size assembly from header bytes four to seven
   always_comb begin
      case (pos_ff[1:0])
         2'd0:    size_new = size_ff | {24'b0, file_byte};
         2'd1:    size_new = size_ff | {16'b0, file_byte, 8'b0};
         2'd2:    size_new = size_ff | {8'b0, file_byte, 16'b0};
         default: size_new = size_ff | {file_byte, 24'b0};
      endcase
   end

   // magic check over the riff header
   always_comb begin
      magic_cur = magic_ff;
      if (offset_ff < 32'd4) begin
         magic_cur = magic_ff && (file_byte == riff_char(offset_ff[1:0]));
      end else if (offset_ff >= 32'd8 && offset_ff < 32'd12) begin
         magic_cur = magic_ff && (file_byte == wave_char(offset_ff[1:0]));
      end
   end

   // expected fmt body bytes
   always_comb begin
      case (pos_ff[1:0])
         2'd0:    rate_byte = sample_rate[7:0];
         2'd1:    rate_byte = sample_rate[15:8];
         2'd2:    rate_byte = sample_rate[23:16];
         default: rate_byte = sample_rate[31:24];
      endcase
      fmt_check = 1'b0;
      fmt_want  = 8'd0;
      if (pos_ff[31:4] == 28'd0) begin
         case (pos_ff[3:0])
            4'd0:    begin fmt_check = 1'b1; fmt_want = 8'd1; end
            4'd1:    begin fmt_check = 1'b1; fmt_want = 8'd0; end
            4'd2:    begin fmt_check = 1'b1; fmt_want = 8'd1; end
            4'd3:    begin fmt_check = 1'b1; fmt_want = 8'd0; end
            4'd4, 4'd5, 4'd6, 4'd7: begin
               fmt_check = 1'b1;
               fmt_want  = rate_byte;
            end
            4'd14:   begin fmt_check = 1'b1; fmt_want = 8'd16; end
            4'd15:   begin fmt_check = 1'b1; fmt_want = 8'd0; end
            default: begin fmt_check = 1'b0; fmt_want = 8'd0; end
         endcase
      end
   end

   // next state and result for one byte
   always_comb begin
      logic       fail_hit;
      logic [2:0] fail_code;
      logic       fok_cur;

      fail_hit  = 1'b0;
      fail_code = ST_OK;
      fok_cur   = fok_ff;

      phase_in  = phase_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      idm_in    = idm_ff;
      fseen_in  = fseen_ff;
      fok_in    = fok_ff;
      magic_in  = magic_ff;
      low_in    = low_ff;
      left_in   = left_ff;

      result.valid  = 1'b0;
      result.sample = 16'sd0;
      result.status = ST_OK;
      result.last   = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == 32'd0 && fl_short) begin
               fail_hit  = 1'b1;
               fail_code = ST_NOT_RIFF;
            end else begin
               magic_in = magic_cur;
               if (offset_ff >= 32'd11) begin
                  if (!magic_cur) begin
                     fail_hit  = 1'b1;
                     fail_code = ST_NOT_RIFF;
                  end else if (hdr_no_room) begin
                     fail_hit  = 1'b1;
                     fail_code = ST_NO_DATA;
                  end else begin
                     phase_in = PH_HEAD;
                     pos_in   = 32'd0;
                     size_in  = 32'd0;
                     idm_in   = 2'b11;
                  end
               end
            end
         end
         PH_HEAD: begin
            pos_in = {29'b0, pos_ff[2:0]} + 32'd1;
            if (!pos_ff[2]) begin
               // chunk id compare against both candidates
               idm_in[0] = idm_ff[0] && (file_byte == fmt_char(pos_ff[1:0]));
               idm_in[1] = idm_ff[1] && (file_byte == data_char(pos_ff[1:0]));
            end else begin
               size_in = size_new;
               if (pos_ff[1:0] == 2'd3) begin
                  pos_in = 32'd0;
                  if (head_trunc) begin
                     fail_hit  = 1'b1;
                     fail_code = ST_TRUNC;
                  end else if (idm_ff[0]) begin
                     if (size_new < FMT_MIN_SIZE) begin
                        fail_hit  = 1'b1;
                        fail_code = ST_FMT_SHORT;
                     end else begin
                        kind_in  = KIND_FMT;
                        fok_in   = 1'b1;
                        phase_in = PH_BODY;
                     end
                  end else if (idm_ff[1]) begin
                     if (!fseen_ff) begin
                        fail_hit  = 1'b1;
                        fail_code = ST_NO_FMT;
                     end else if (sample_total == 31'd0 || sample_total > max_frames) begin
                        fail_hit  = 1'b1;
                        fail_code = ST_BAD_COUNT;
                     end else begin
                        left_in  = sample_total;
                        phase_in = PH_DATA;
                     end
                  end else begin
                     kind_in = KIND_OTHER;
                     if (size_new == 32'd0) begin
                        // empty chunk ends at once
                        if (head_no_room) begin
                           fail_hit  = 1'b1;
                           fail_code = ST_NO_DATA;
                        end else begin
                           phase_in = PH_HEAD;
                           size_in  = 32'd0;
                           idm_in   = 2'b11;
                        end
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
            end
         end
         PH_BODY: begin
            if (kind_ff == KIND_FMT) begin
               fok_cur = fok_ff && (!fmt_check || file_byte == fmt_want);
               fok_in  = fok_cur;
            end
            if (kind_ff == KIND_FMT && pos_ff == 32'd15 && !fok_cur) begin
               fail_hit  = 1'b1;
               fail_code = ST_BAD_FMT;
            end else begin
               if (kind_ff == KIND_FMT && pos_ff == 32'd15) begin
                  fseen_in = 1'b1;
               end
               if (body_last) begin
                  if (body_no_room) begin
                     fail_hit  = 1'b1;
                     fail_code = ST_NO_DATA;
                  end else begin
                     phase_in = size_ff[0] ? PH_PAD : PH_HEAD;
                     pos_in   = 32'd0;
                     size_in  = 32'd0;
                     idm_in   = 2'b11;
                  end
               end else begin
                  pos_in = pos_ff + 32'd1;
               end
            end
         end
         PH_PAD: begin
            phase_in = PH_HEAD;
            pos_in   = 32'd0;
         end
         PH_DATA: begin
            if (!pos_ff[0]) begin
               low_in = file_byte;
            end else begin
               result.valid  = 1'b1;
               result.sample = {file_byte, low_ff};
               result.status = ST_OK;
               result.last   = (left_dec == 31'd0);
               left_in       = left_dec;
               if (left_dec == 31'd0) begin
                  phase_in = PH_DONE;
               end
            end
            pos_in = {31'b0, !pos_ff[0]};
         end
         default: begin
         end
      endcase

      // error result ends the file
      if (fail_hit) begin
         phase_in      = PH_DONE;
         result.valid  = 1'b1;
         result.sample = 16'sd0;
         result.status = fail_code;
         result.last   = 1'b1;
      end

      // end of file restarts the parse
      if (file_end) begin
         phase_in  = PH_HEADER;
         offset_in = 32'd0;
         size_in   = 32'd0;
         pos_in    = 32'd0;
         kind_in   = KIND_OTHER;
         idm_in    = 2'b11;
         fseen_in  = 1'b0;
         fok_in    = 1'b1;
         magic_in  = 1'b1;
         low_in    = 8'd0;
         left_in   = 31'd0;
      end else begin
         offset_in = offset_inc[31:0];
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= 32'd0;
         size_ff   <= 32'd0;
         pos_ff    <= 32'd0;
         kind_ff   <= KIND_OTHER;
         idm_ff    <= 2'b11;
         fseen_ff  <= 1'b0;
         fok_ff    <= 1'b1;
         magic_ff  <= 1'b1;
         low_ff    <= 8'd0;
         left_ff   <= 31'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         idm_ff    <= idm_in;
         fseen_ff  <= fseen_in;
         fok_ff    <= fok_in;
         magic_ff  <= magic_in;
         low_ff    <= low_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/wpcp_out_stage.sv
// output register for result transactions
`default_nettype none

module wpcp_out_stage
   import wpcp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire wpcp_result_type  result,
   output logic                  space,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic signed [15:0]    rsp_sample,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   logic               valid_ff, valid_in;
   logic signed [15:0] sample_ff;
   logic [2:0]         status_ff;
   logic               last_ff;

   // room for a new result when empty or being drained
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance && result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         sample_ff <= result.sample;
         status_ff <= result.status;
         last_ff   <= result.last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

FILE: design/wav_pcm_chunk_parser.sv
// top level of the riff wave 16-bit pcm mono stream parser
//
// Write file_length (csr index 0) before streaming a file; that write also
// restarts the parse. sample_rate (index 1) and max_frames (index 2) apply
// at once. Writes are taken in the cycle csr_write_en is high.
// The file is fed one byte per req transaction. Each byte yields zero or one
// rsp transaction: a 16-bit sample on every second data byte, or an error
// status with last set. After an error or the final sample, bytes give no
// result until file_length bytes are consumed, then the next byte starts
// a new file.
// An accepted byte waits in the input register; the parse state update works on
// it combinationally, and the output register captures its result when it has
// space. Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, one result waits in the output register and one
// byte in the input register; req_ready then drops until rsp_ready returns.
// Reset clears both registers, the parse state and the csr values to 12,
// 48000 and 96000; the block is ready in the first cycle after reset.
`default_nettype none

module wav_pcm_chunk_parser
   import wpcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_file_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic [2:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0]     file_length_ff;
   logic [31:0]     sample_rate_ff;
   logic [30:0]     max_frames_ff;
   logic            restart;
   logic            byte_valid;
   logic [7:0]      byte_data;
   logic            space;
   logic            advance;
   wpcp_result_type result;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= FILE_LENGTH_RST;
         sample_rate_ff <= SAMPLE_RATE_RST;
         max_frames_ff  <= MAX_FRAMES_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FILE_LENGTH: file_length_ff <= csr_wdata;
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata;
            CSR_MAX_FRAMES:  max_frames_ff  <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   assign restart = csr_write_en && (csr_index == CSR_FILE_LENGTH);
   assign advance = byte_valid && space;

   wpcp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_file_byte (req_file_byte),
      .advance       (advance),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data)
   );

   wpcp_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .advance     (advance),
      .file_byte   (byte_data),
      .file_length (file_length_ff),
      .sample_rate (sample_rate_ff),
      .max_frames  (max_frames_ff),
      .result      (result)
   );

   wpcp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire
